@@ sv/fsbt_pkg.sv @@
// Shared types and constants of the flush size bandwidth tuner.
// Used by flush_size_bandwidth_tuner; depends on nothing.
package fsbt_pkg;

    localparam int SEC_W     = 32;
    localparam int USEC_W    = 20;
    localparam int BW_W      = 40;
    localparam int LEN_W     = 32;
    localparam int STRIDE_W  = 29;
    localparam int RND_W     = 16;
    localparam int HOLD_W    = 8;
    localparam int ELAP_W    = 52;
    localparam int MUL_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 40;

    localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;
    localparam logic [USEC_W-1:0] USEC_MAX     = 20'd999999;

    localparam logic [BW_W-1:0]     EXPECTED_BW_RST = 40'd67108864;
    localparam logic [STRIDE_W-1:0] STRIDE_RST      = 29'd2097152;
    localparam logic [LEN_W-1:0]    INIT_LENGTH_RST = 32'd8388608;
    localparam logic [BW_W-1:0]     FLOOR_BW_RST    = 40'd51200;
    localparam logic [BW_W-1:0]     TOLERANCE_RST   = 40'd10240;
    localparam logic [HOLD_W-1:0]   HOLD_SEC_RST    = 8'd3;

    typedef enum logic [1:0] {
        STAT_BASELINE = 2'd0,
        STAT_TOO_SOON = 2'd1,
        STAT_MEASURED = 2'd2,
        STAT_ADJUSTED = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPECTED_BW  = 3'd0,
        CFG_STRIDE       = 3'd1,
        CFG_INIT_LENGTH  = 3'd2,
        CFG_FLOOR_BW     = 3'd3,
        CFG_TOLERANCE    = 3'd4,
        CFG_HOLD_SECONDS = 3'd5
    } cfg_idx_t;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_EVAL   = 10'b00_0000_0010,
        ST_MUL_T  = 10'b00_0000_0100,
        ST_MUL_LO = 10'b00_0000_1000,
        ST_MUL_HI = 10'b00_0001_0000,
        ST_ACC    = 10'b00_0010_0000,
        ST_DIV_GO = 10'b00_0100_0000,
        ST_DIV    = 10'b00_1000_0000,
        ST_DECIDE = 10'b01_0000_0000,
        ST_FINISH = 10'b10_0000_0000
    } state_t;

endpackage

@@ sv/flush_size_bandwidth_tuner.sv @@
// Top level of the flush size bandwidth tuner: sequencer, shared multiplier and tuning state.
// Depends on fsbt_pkg and instantiates the serial divider fsbt_div.
//
// Usage. Each beat on the s_axis channel is one time sample (seconds, microseconds,
// running byte count and a random coin bit). Each sample yields exactly one beat on
// the m_axis channel carrying the current flush length, the last measured bandwidth,
// the direction and the round count, with a status code in tuser.
// The cfg channel writes the tuning registers; it is always ready, and it is meant to
// be written only while no sample is in flight.
// Sequence. A baseline or too-early sample goes from the evaluate step straight to the
// finish step, which loads the output register. A measured sample first forms its
// products on the one shared 32x32 multiplier, then runs the serial divider, which
// retires one quotient bit per cycle over the COUNTER_BITS + 20 bits of the scaled
// byte delta, then passes through the decide and finish steps to hand over. The block
// takes one sample at a time; s_axis_tready is high only while the sequencer is idle.
// Reset. rst_n clears the sequencer, the output valid flag and the tuning state, and
// returns every configuration register to its default; the flush length returns to
// the default initial length.
// Stalls. The result sits in an output register. If the receiver holds off, the
// block still takes the next sample and works on it; it only waits at the end for the
// output register to free up.
module flush_size_bandwidth_tuner #(
    parameter int COUNTER_BITS = 48
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // s_axis_tdata from bit 0 up: now_sec, now_usec, total_bytes, coin, zero pad.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((COUNTER_BITS + 60) / 8) * 8 - 1:0] s_axis_tdata,
    // m_axis_tdata from bit 0 up: flush_length, measured_bw, step_down, round_count,
    // zero pad.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [95:0]                           m_axis_tdata,
    // m_axis_tuser from bit 0 up: status.
    output logic [1:0]                            m_axis_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fsbt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fsbt_pkg::CFG_DAT_W-1:0]        cfg_data
);

    import fsbt_pkg::*;

    localparam int CB       = COUNTER_BITS;
    localparam int IN_W     = ((CB + 60) / 8) * 8;
    localparam int NUM_W    = CB + USEC_W;
    localparam int USEC_LSB = SEC_W;
    localparam int BYTE_LSB = SEC_W + USEC_W;
    localparam int COIN_BIT = SEC_W + USEC_W + CB;
    localparam int OUT_W    = LEN_W + BW_W + 1 + RND_W;

    // Moves the flush length by one or two strides and keeps it in [stride, max].
    function automatic logic [LEN_W-1:0] move_len(
        input logic [LEN_W-1:0]    len,
        input logic [STRIDE_W-1:0] s,
        input logic                up,
        input logic                dbl
    );
        logic [STRIDE_W:0]   k;
        logic [LEN_W+1:0]    sum;
        logic [STRIDE_W+1:0] low_bound;
        logic [LEN_W-1:0]    res;
        k         = dbl ? {s, 1'b0} : {1'b0, s};
        sum       = {2'b00, len} + (LEN_W + 2)'(k);
        low_bound = (STRIDE_W + 2)'(k) + (STRIDE_W + 2)'(s);
        if (up)
        begin
            res = (sum[LEN_W+1:LEN_W] != 2'b00) ? {LEN_W{1'b1}} : sum[LEN_W-1:0];
        end
        else if (len < LEN_W'(low_bound))
        begin
            res = LEN_W'(s);
        end
        else
        begin
            res = len - LEN_W'(k);
        end
        return res;
    endfunction

    // Configuration registers.
    logic [BW_W-1:0]     expected_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [BW_W-1:0]     floor_reg;
    logic [BW_W-1:0]     tol_reg;
    logic [HOLD_W-1:0]   hold_reg;

    // Sequencer and tuning state.
    state_t              state_reg;
    state_t              state_next;
    logic                started_reg;
    logic [SEC_W-1:0]    prev_sec_reg;
    logic [USEC_W-1:0]   prev_usec_reg;
    logic [CB-1:0]       prev_bytes_reg;
    logic [BW_W-1:0]     prev_bw_reg;
    logic [LEN_W-1:0]    length_reg;
    logic                dir_reg;
    logic [RND_W-1:0]    rounds_reg;
    status_t             status_reg;

    // Sample and datapath registers.
    logic [SEC_W-1:0]    sec_reg;
    logic [USEC_W-1:0]   usec_reg;
    logic [CB-1:0]       bytes_reg;
    logic                coin_reg;
    logic [2*MUL_W-1:0]  prod_reg;
    logic [ELAP_W-1:0]   elapsed_reg;
    logic [NUM_W-1:0]    num_reg;
    logic                lim_reg;

    // Output register.
    logic                m_valid_reg;
    status_t             out_status_reg;
    logic [OUT_W-1:0]    out_data_reg;

    logic                in_beat;
    logic                out_free;
    logic                out_load;
    logic [USEC_W-1:0]   usec_in;
    logic                too_soon;
    logic [SEC_W-1:0]    sec_diff;
    logic [CB-1:0]       delta;
    logic [2*MUL_W-1:0]  delta_ext;
    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic                div_start;
    logic                div_done;
    logic [BW_W-1:0]     div_q;

    logic                in_band;
    logic                drop;
    logic [RND_W-1:0]    rounds_inc;
    logic                mv_en;
    logic                mv_up;
    logic                mv_dbl;
    logic                dir_dec;
    logic [RND_W-1:0]    rounds_dec;
    status_t             status_dec;
    logic [LEN_W-1:0]    length_dec;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign out_load      = (state_reg == ST_FINISH) && out_free;

    // Microseconds beyond the second are taken as the last microsecond.
    assign usec_in = (s_axis_tdata[USEC_LSB +: USEC_W] > USEC_MAX) ?
                     USEC_MAX : s_axis_tdata[USEC_LSB +: USEC_W];

    // A sample no later than the hold time past the last measurement is skipped.
    assign too_soon  = {1'b0, sec_reg} <= ({1'b0, prev_sec_reg} + (SEC_W + 1)'(hold_reg));
    assign sec_diff  = sec_reg - prev_sec_reg;
    assign delta     = bytes_reg - prev_bytes_reg;
    assign delta_ext = (2 * MUL_W)'(delta);

    // Operand selection for the shared multiplier. Outside the measurement steps it
    // forms (rounds + 2) * stride for the shrink limit.
    always_comb
    begin
        unique case (state_reg)
            ST_MUL_T:
            begin
                mul_a = sec_diff;
                mul_b = MUL_W'(USEC_PER_SEC);
            end
            ST_MUL_LO:
            begin
                mul_a = delta_ext[MUL_W-1:0];
                mul_b = MUL_W'(USEC_PER_SEC);
            end
            ST_MUL_HI:
            begin
                mul_a = delta_ext[2*MUL_W-1:MUL_W];
                mul_b = MUL_W'(USEC_PER_SEC);
            end
            default:
            begin
                mul_a = MUL_W'(rounds_reg) + MUL_W'(2);
                mul_b = MUL_W'(stride_reg);
            end
        endcase
    end

    assign div_start = (state_reg == ST_DIV_GO);

    fsbt_div #(
        .NUM_W (NUM_W),
        .DEN_W (ELAP_W),
        .Q_W   (BW_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (elapsed_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    // Hill-climbing decision on a fresh bandwidth value.
    always_comb
    begin
        in_band    = (div_q >= floor_reg) && (div_q < expected_reg);
        drop       = (prev_bw_reg > div_q) && ((prev_bw_reg - div_q) > tol_reg);
        rounds_inc = (rounds_reg == {RND_W{1'b1}}) ? rounds_reg : rounds_reg + RND_W'(1);
        mv_en      = 1'b0;
        mv_up      = 1'b0;
        mv_dbl     = 1'b0;
        dir_dec    = dir_reg;
        rounds_dec = rounds_reg;
        status_dec = STAT_MEASURED;
        if (in_band)
        begin
            status_dec = STAT_ADJUSTED;
            if (drop)
            begin
                mv_en = 1'b1;
                if (rounds_reg != '0)
                begin
                    // Undo the last move.
                    mv_up      = dir_reg;
                    mv_dbl     = !dir_reg;
                    rounds_dec = rounds_reg - RND_W'(1);
                end
                else
                begin
                    // Start over in a random direction.
                    dir_dec    = !coin_reg;
                    mv_up      = coin_reg;
                    mv_dbl     = coin_reg;
                    rounds_dec = rounds_inc;
                end
            end
            else if (!(dir_reg && lim_reg))
            begin
                // Keep going the same way.
                mv_en      = 1'b1;
                mv_up      = !dir_reg;
                mv_dbl     = !dir_reg;
                rounds_dec = rounds_inc;
            end
        end
        length_dec = mv_en ? move_len(length_reg, stride_reg, mv_up, mv_dbl) : length_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_axis_tvalid) state_next = ST_EVAL;
            ST_EVAL:   state_next = (!started_reg || too_soon) ? ST_FINISH : ST_MUL_T;
            ST_MUL_T:  state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_ACC;
            ST_ACC:    state_next = ST_DIV_GO;
            ST_DIV_GO: state_next = ST_DIV;
            ST_DIV:    if (div_done) state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_FINISH;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= EXPECTED_BW_RST;
            stride_reg   <= STRIDE_RST;
            floor_reg    <= FLOOR_BW_RST;
            tol_reg      <= TOLERANCE_RST;
            hold_reg     <= HOLD_SEC_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // The initial length only matters at reset, and reset also restores its
            // default, so a write to it has nothing to change.
            unique case (cfg_index)
                CFG_EXPECTED_BW:  expected_reg <= cfg_data[BW_W-1:0];
                CFG_STRIDE:       stride_reg   <= cfg_data[STRIDE_W-1:0];
                CFG_INIT_LENGTH:  ;
                CFG_FLOOR_BW:     floor_reg    <= cfg_data[BW_W-1:0];
                CFG_TOLERANCE:    tol_reg      <= cfg_data[BW_W-1:0];
                CFG_HOLD_SECONDS: hold_reg     <= cfg_data[HOLD_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            started_reg    <= 1'b0;
            prev_sec_reg   <= '0;
            prev_usec_reg  <= '0;
            prev_bytes_reg <= '0;
            prev_bw_reg    <= '0;
            length_reg     <= INIT_LENGTH_RST;
            dir_reg        <= 1'b0;
            rounds_reg     <= '0;
            status_reg     <= STAT_BASELINE;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_EVAL)
            begin
                if (!started_reg)
                begin
                    started_reg    <= 1'b1;
                    prev_sec_reg   <= sec_reg;
                    prev_usec_reg  <= usec_reg;
                    prev_bytes_reg <= bytes_reg;
                    status_reg     <= STAT_BASELINE;
                end
                else if (too_soon)
                begin
                    status_reg <= STAT_TOO_SOON;
                end
            end
            if (state_reg == ST_DECIDE)
            begin
                prev_sec_reg   <= sec_reg;
                prev_usec_reg  <= usec_reg;
                prev_bytes_reg <= bytes_reg;
                prev_bw_reg    <= div_q;
                length_reg     <= length_dec;
                dir_reg        <= dir_dec;
                rounds_reg     <= rounds_dec;
                status_reg     <= status_dec;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            sec_reg   <= s_axis_tdata[SEC_W-1:0];
            usec_reg  <= usec_in;
            bytes_reg <= s_axis_tdata[BYTE_LSB +: CB];
            coin_reg  <= s_axis_tdata[COIN_BIT];
        end
        prod_reg <= mul_a * mul_b;
        if (state_reg == ST_MUL_LO)
        begin
            // The sum is never negative: at least one whole second has gone by.
            elapsed_reg <= prod_reg[ELAP_W-1:0] + ELAP_W'(usec_reg) - ELAP_W'(prev_usec_reg);
        end
        if (state_reg == ST_MUL_HI)
        begin
            num_reg <= NUM_W'(prod_reg);
        end
        if (state_reg == ST_ACC)
        begin
            num_reg <= num_reg + NUM_W'({prod_reg, {MUL_W{1'b0}}});
        end
        if (state_reg == ST_DIV)
        begin
            // The shrink limit holds when length / stride <= rounds + 1.
            lim_reg <= (2 * MUL_W)'(length_reg) < prod_reg;
        end
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_data_reg   <= {rounds_reg, dir_reg, prev_bw_reg, length_reg};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(96 - OUT_W){1'b0}}, out_data_reg};
    assign m_axis_tuser  = out_status_reg;

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide step");

    // An accepted sample is evaluated in the very next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg == ST_EVAL))
        else $error("accepted sample was not evaluated");

    // One decision moves the round count by at most one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) |=>
            (rounds_reg == $past(rounds_reg)) ||
            (rounds_reg == $past(rounds_reg) + RND_W'(1)) ||
            (rounds_reg == $past(rounds_reg) - RND_W'(1)))
        else $error("round count jumped by more than one");

endmodule

@@ sv/fsbt_div.sv @@
// Serial restoring divider with a saturating quotient, one quotient bit per cycle.
// Used by flush_size_bandwidth_tuner; stands alone.
module fsbt_div #(
    parameter int NUM_W = 68,
    parameter int DEN_W = 52,
    parameter int Q_W   = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [Q_W-1:0]   quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [Q_W-1:0]   q_reg;
    logic             sat_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // Bring down the next numerator bit and try to subtract the divisor.
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
            sat_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            q_reg   <= {q_reg[Q_W-2:0], ge};
            // A one above the quotient width means the result saturates.
            if (ge && (cnt_reg > CNT_W'(Q_W)))
            begin
                sat_reg <= 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quot = sat_reg ? {Q_W{1'b1}} : q_reg;

endmodule
